// ----- rtl/core/gcr_pkg.sv -----
// Shared types, constants and the arctangent table for the great-circle rotation.
package gcr_pkg;

  // Angle field width and CORDIC depth.
  localparam int FIELD_W = 32;
  localparam int CORDIC_ITERATIONS = 30;

  // Vector components: signed, 2^32 is 1.0, with headroom for five CORDIC gains.
  localparam int COMP_W = 40;
  // Angle accumulators: signed, 2^32 is one turn, with headroom past a half turn.
  localparam int ACC_W = 34;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [FIELD_W-1:0] angle_t;

  // Unit length and the quarter and half turns.
  localparam comp_t UNIT = comp_t'(64'sh1_0000_0000);
  localparam acc_t QUARTER = acc_t'(64'sh4000_0000);
  localparam acc_t HALF = acc_t'(64'sh8000_0000);
  localparam angle_t POLE_NORTH = 32'h4000_0000;
  localparam angle_t POLE_SOUTH = 32'hC000_0000;
  localparam angle_t HALF_TURN = 32'h8000_0000;

  // Configuration register indexes.
  localparam logic REG_NODE = 1'b0;
  localparam logic REG_INCL = 1'b1;
  localparam angle_t NODE_RESET = 32'd1133394261;
  localparam angle_t INCL_RESET = 32'd387742265;

  // A phase either rotates by a given angle or vectors to find an angle.
  typedef enum logic {
    MODE_ROTATE,
    MODE_VECTOR
  } phase_mode_t;

  // Item data that rides alongside the vector lanes.
  typedef struct packed {
    logic direction;
    angle_t lon;
    angle_t lon_res;
  } side_t;

  // atan(2^-i) in binary angle units, 2^32 per turn.
  localparam angle_t ATAN_TAB [CORDIC_ITERATIONS] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001
  };

endpackage

// ----- rtl/core/gcr_phase.sv -----
// One pipelined CORDIC phase: a rotate or vector lane plus a gain-only lane.
module gcr_phase (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  gcr_pkg::phase_mode_t mode,
  input  logic                in_valid,
  input  gcr_pkg::comp_t      in_x,
  input  gcr_pkg::comp_t      in_y,
  input  gcr_pkg::angle_t     in_ang,
  input  gcr_pkg::comp_t      in_g,
  input  gcr_pkg::side_t      in_side,
  output logic                out_valid,
  output gcr_pkg::comp_t      out_x,
  output gcr_pkg::comp_t      out_y,
  output gcr_pkg::angle_t     out_ang,
  output gcr_pkg::comp_t      out_g,
  output gcr_pkg::side_t      out_side
);

  localparam int N = gcr_pkg::CORDIC_ITERATIONS;

  // Stage k holds the lanes after k iterations; stage 0 holds the prescaled values.
  logic            vld   [N+1];
  gcr_pkg::comp_t  x     [N+1];
  gcr_pkg::comp_t  y     [N+1];
  gcr_pkg::acc_t   a     [N+1];
  gcr_pkg::comp_t  g     [N+1];
  gcr_pkg::comp_t  gy    [N+1];
  gcr_pkg::acc_t   ga    [N+1];
  logic            zero  [N+1];
  gcr_pkg::side_t  side  [N+1];

  gcr_pkg::comp_t  pre_x;
  gcr_pkg::comp_t  pre_y;
  gcr_pkg::acc_t   pre_a;
  gcr_pkg::acc_t   ang_s;
  logic            pre_zero;

  // Prescale: fold rotations past a quarter turn, or move a vector into the right half plane.
  always_comb begin
    ang_s = gcr_pkg::acc_t'(signed'(in_ang));
    pre_x = in_x;
    pre_y = in_y;
    pre_a = '0;
    pre_zero = 1'b0;
    unique case (mode)
      gcr_pkg::MODE_ROTATE: begin
        pre_a = ang_s;
        if (ang_s > gcr_pkg::QUARTER) begin
          pre_a = ang_s - gcr_pkg::HALF;
          pre_x = -in_x;
          pre_y = -in_y;
        end else if (ang_s < -gcr_pkg::QUARTER) begin
          pre_a = ang_s + gcr_pkg::HALF;
          pre_x = -in_x;
          pre_y = -in_y;
        end
      end
      gcr_pkg::MODE_VECTOR: begin
        pre_zero = (in_x == '0) && (in_y == '0);
        if (in_x < 0) begin
          pre_x = -in_x;
          pre_y = -in_y;
          pre_a = gcr_pkg::HALF;
        end
      end
      default: begin
        pre_a = '0;
      end
    endcase
  end

  // Prescale register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= pre_x;
      y[0]    <= pre_y;
      a[0]    <= pre_a;
      g[0]    <= in_g;
      gy[0]   <= '0;
      ga[0]   <= '0;
      zero[0] <= pre_zero;
      side[0] <= in_side;
    end
  end

  // One micro-rotation per stage for both lanes.
  for (genvar i = 0; i < N; i++) begin : g_iter
    logic           s;
    logic           sg;
    gcr_pkg::acc_t  t;

    assign s  = (mode == gcr_pkg::MODE_ROTATE) ? ~a[i][gcr_pkg::ACC_W-1]
                                                : y[i][gcr_pkg::COMP_W-1];
    assign sg = ~ga[i][gcr_pkg::ACC_W-1];
    assign t  = gcr_pkg::acc_t'(gcr_pkg::ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[i+1]    <= s ? x[i] - (y[i] >>> i) : x[i] + (y[i] >>> i);
        y[i+1]    <= s ? y[i] + (x[i] >>> i) : y[i] - (x[i] >>> i);
        a[i+1]    <= s ? a[i] - t : a[i] + t;
        g[i+1]    <= sg ? g[i] - (gy[i] >>> i) : g[i] + (gy[i] >>> i);
        gy[i+1]   <= sg ? gy[i] + (g[i] >>> i) : gy[i] - (g[i] >>> i);
        ga[i+1]   <= sg ? ga[i] - t : ga[i] + t;
        zero[i+1] <= zero[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_x     = x[N];
  assign out_y     = y[N];
  assign out_ang   = zero[N] ? '0 : a[N][gcr_pkg::FIELD_W-1:0];
  assign out_g     = g[N];
  assign out_side  = side[N];

endmodule

// ----- rtl/core/great_circle_coordinate_rotation.sv -----
// Top level of the great-circle coordinate rotation pipeline.
// Converts longitude/latitude pairs between equatorial and great-circle coordinates
// (direction 0: equatorial to great circle, 1: the reverse), with the circle's node and
// inclination held in two write-only registers (index 0 node, index 1 inclination).
// One item is accepted per clock while the output is not stalled, through five chained
// CORDIC phases of 30 iterations each (latitude rotation, longitude rotation, inclination
// rotation, longitude vectoring, latitude vectoring) and one output stage. A stall on the
// output freezes the whole pipeline. Write the registers only while no item is in flight.
module great_circle_coordinate_rotation (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        direction,
  input  logic [31:0] lon_in,
  input  logic signed [31:0] lat_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] lon_out,
  output logic signed [31:0] lat_out
);

  gcr_pkg::angle_t node_angle;
  gcr_pkg::angle_t inclination_angle;
  logic en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_angle        <= gcr_pkg::NODE_RESET;
      inclination_angle <= gcr_pkg::INCL_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        gcr_pkg::REG_NODE: node_angle        <= wr_data;
        gcr_pkg::REG_INCL: inclination_angle <= wr_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a finished item is waiting.
  assign en = ~out_valid | out_ready;
  assign in_ready = en;

  logic            v1, v2, v3, v4, v5;
  gcr_pkg::comp_t  x1, y1, g1, x2, y2, g2, x3, y3, g3, x4, y4, g4, x5, y5, g5;
  gcr_pkg::angle_t a1, a2, a3, a4, a5;
  gcr_pkg::side_t  s0, s1, s2, s3, s4, s4n, s5;

  assign s0 = '{direction: direction, lon: lon_in, lon_res: '0};

  // Phase 1: unit vector rotated by the latitude.
  gcr_phase u_lat (
    .clk, .rst, .en, .mode(gcr_pkg::MODE_ROTATE),
    .in_valid(in_valid & en), .in_x(gcr_pkg::UNIT), .in_y('0),
    .in_ang(lat_in), .in_g('0), .in_side(s0),
    .out_valid(v1), .out_x(x1), .out_y(y1), .out_ang(a1), .out_g(g1), .out_side(s1)
  );

  // Phase 2: rotate by longitude minus node; bring z to the same gain.
  gcr_phase u_lon (
    .clk, .rst, .en, .mode(gcr_pkg::MODE_ROTATE),
    .in_valid(v1), .in_x(x1), .in_y('0),
    .in_ang(s1.lon - node_angle), .in_g(y1), .in_side(s1),
    .out_valid(v2), .out_x(x2), .out_y(y2), .out_ang(a2), .out_g(g2), .out_side(s2)
  );

  // Phase 3: rotate (y, z) about x by plus or minus the inclination; gain on x.
  gcr_phase u_inc (
    .clk, .rst, .en, .mode(gcr_pkg::MODE_ROTATE),
    .in_valid(v2), .in_x(y2), .in_y(g2),
    .in_ang(s2.direction ? inclination_angle : -inclination_angle),
    .in_g(x2), .in_side(s2),
    .out_valid(v3), .out_x(x3), .out_y(y3), .out_ang(a3), .out_g(g3), .out_side(s3)
  );

  // Phase 4: longitude from atan2(y, x); gain on z.
  gcr_phase u_vlon (
    .clk, .rst, .en, .mode(gcr_pkg::MODE_VECTOR),
    .in_valid(v3), .in_x(g3), .in_y(x3),
    .in_ang('0), .in_g(y3), .in_side(s3),
    .out_valid(v4), .out_x(x4), .out_y(y4), .out_ang(a4), .out_g(g4), .out_side(s4)
  );

  always_comb begin
    s4n = s4;
    s4n.lon_res = a4 + node_angle;
  end

  // Phase 5: latitude from atan2(z, r).
  gcr_phase u_vlat (
    .clk, .rst, .en, .mode(gcr_pkg::MODE_VECTOR),
    .in_valid(v4), .in_x(x4), .in_y(g4),
    .in_ang('0), .in_g('0), .in_side(s4n),
    .out_valid(v5), .out_x(x5), .out_y(y5), .out_ang(a5), .out_g(g5), .out_side(s5)
  );

  // Fold latitudes past a pole and zero the longitude at an exact pole.
  logic signed [31:0] la;
  logic signed [31:0] lat_fold;
  logic [31:0]        lon_fold;

  always_comb begin
    la = signed'(a5);
    lat_fold = la;
    lon_fold = s5.lon_res;
    if (la > 32'sh4000_0000) begin
      lat_fold = signed'(gcr_pkg::HALF_TURN - a5);
      lon_fold = s5.lon_res + gcr_pkg::HALF_TURN;
    end else if (la < -32'sh4000_0000) begin
      lat_fold = signed'(gcr_pkg::HALF_TURN - a5);
      lon_fold = s5.lon_res + gcr_pkg::HALF_TURN;
    end
    if (lat_fold == signed'(gcr_pkg::POLE_NORTH) || lat_fold == signed'(gcr_pkg::POLE_SOUTH)) begin
      lon_fold = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lon_out <= lon_fold;
      lat_out <= lat_fold;
    end
  end

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the great-circle coordinate rotation pipeline.
`timescale 1ns / 1ps

module tb;

  // Direction codes of an input item.
  localparam logic DIR_TO_CIRCLE = 1'b0;
  localparam logic DIR_TO_EQUATOR = 1'b1;

  localparam int PIPE_DEPTH = 156;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 220;

  localparam longint TURN_L = 64'sd1 << 32;
  localparam longint MASK_L = TURN_L - 1;
  localparam longint HALF_L = TURN_L >>> 1;
  localparam longint QUART_L = TURN_L >>> 2;

  typedef struct {
    logic [31:0] lon;
    logic [31:0] lat;
  } coord_t;

  typedef struct {
    logic dir;
    logic [31:0] lon;
    logic [31:0] lat;
  } probe_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic wr_index;
  logic [31:0] wr_data;
  logic in_valid;
  logic in_ready;
  logic direction;
  logic [31:0] lon_in;
  logic signed [31:0] lat_in;
  logic out_valid;
  logic out_ready;
  logic [31:0] lon_out;
  logic signed [31:0] lat_out;

  // Bench copy of the circle registers and the arctangent table.
  logic [31:0] node_reg;
  logic [31:0] incl_reg;
  longint atan_turns [gcr_pkg::CORDIC_ITERATIONS];

  coord_t pending_coords [$];
  bit failed = 1'b0;
  bit calm = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  great_circle_coordinate_rotation DUT (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .direction(direction),
    .lon_in(lon_in), .lat_in(lat_in), .out_valid(out_valid), .out_ready(out_ready),
    .lon_out(lon_out), .lat_out(lat_out)
  );

  // Arctangent of 2^-i in binary angle units, from an alternating series in radians.
  function automatic void build_atan_turns();
    logic [63:0] rad;
    logic [63:0] term;
    logic [63:0] turns;
    logic [127:0] prod;
    int e;
    for (int i = 0; i < gcr_pkg::CORDIC_ITERATIONS; i++) begin
      if (i == 0) begin
        turns = 64'd1 << 59;
      end else begin
        rad = 0;
        for (int k = 0; k < 64; k++) begin
          e = i * (2 * k + 1);
          if (e > 62) break;
          term = (64'd1 << (62 - e)) / (2 * k + 1);
          if (k % 2 == 1) rad = rad - term;
          else rad = rad + term;
        end
        prod = {64'd0, rad} * {64'd0, 64'h28BE60DB9391054B};
        turns = prod[127:64];
      end
      atan_turns[i] = longint'((turns + (64'd1 << 29)) >> 30);
    end
  endfunction

  // Angle modulo one turn, as a signed value in [-half, half).
  function automatic longint wrap_signed(input longint ang);
    longint a;
    a = ang & MASK_L;
    return (a >= HALF_L) ? a - TURN_L : a;
  endfunction

  // Rotation CORDIC; turns beyond a quarter go through a half turn and negation.
  function automatic void spin(inout longint px, inout longint py, input longint ang);
    longint a;
    longint dx;
    longint dy;
    a = wrap_signed(ang);
    if (a > QUART_L) begin
      a -= HALF_L;
      px = -px;
      py = -py;
    end else if (a < -QUART_L) begin
      a += HALF_L;
      px = -px;
      py = -py;
    end
    for (int i = 0; i < gcr_pkg::CORDIC_ITERATIONS; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (a >= 0) begin
        px -= dx;
        py += dy;
        a -= atan_turns[i];
      end else begin
        px += dx;
        py -= dy;
        a += atan_turns[i];
      end
    end
  endfunction

  // Vectoring CORDIC: atan2(y, x) mod one turn, and the scaled magnitude.
  function automatic longint heading(input longint x, input longint y, output longint mag);
    longint base;
    longint a;
    longint dx;
    longint dy;
    base = 0;
    a = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      base = HALF_L;
    end
    for (int i = 0; i < gcr_pkg::CORDIC_ITERATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        a += atan_turns[i];
      end else begin
        x -= dx;
        y += dy;
        a -= atan_turns[i];
      end
    end
    mag = x;
    return (base + a) & MASK_L;
  endfunction

  // Scale a lone component by the CORDIC gain.
  function automatic longint with_gain(input longint v);
    longint x;
    longint y;
    x = v;
    y = 0;
    spin(x, y, 0);
    return x;
  endfunction

  // Expected output coordinates of one item under the current circle.
  function automatic coord_t predict_rotation(input logic dir, input logic [31:0] lon,
                                              input logic [31:0] lat);
    longint x, y, z, r, unused, la, lon_res, node, inc;
    coord_t res;
    node = longint'(node_reg);
    inc = longint'(incl_reg);
    x = TURN_L;
    z = 0;
    spin(x, z, longint'(lat));
    y = 0;
    spin(x, y, (longint'(lon) - node) & MASK_L);
    z = with_gain(z);
    spin(y, z, (dir == DIR_TO_EQUATOR) ? inc : ((TURN_L - inc) & MASK_L));
    x = with_gain(x);
    lon_res = (heading(x, y, r) + node) & MASK_L;
    z = with_gain(z);
    la = wrap_signed(heading(r, z, unused));
    // Fold a latitude past a pole back and move to the opposite meridian.
    if (la > QUART_L) begin
      la = HALF_L - la;
      lon_res = (lon_res + HALF_L) & MASK_L;
    end else if (la < -QUART_L) begin
      la = -HALF_L - la;
      lon_res = (lon_res + HALF_L) & MASK_L;
    end
    res.lon = lon_res[31:0];
    res.lat = la[31:0];
    if (res.lat == gcr_pkg::POLE_NORTH || res.lat == gcr_pkg::POLE_SOUTH) res.lon = '0;
    return res;
  endfunction

  // Offer one item, with an optional gap first, and record its expectation on acceptance.
  task automatic offer_item(input logic dir, input logic [31:0] lon, input logic [31:0] lat);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    direction <= dir;
    lon_in <= lon;
    lat_in <= lat;
    do @(posedge clk); while (!in_ready);
    pending_coords.push_back(predict_rotation(dir, lon, lat));
  endtask

  // Let the pipeline drain, then load both circle registers.
  task automatic load_circle(input logic [31:0] node, input logic [31:0] incl);
    in_valid <= 1'b0;
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= gcr_pkg::REG_NODE;
    wr_data <= node;
    @(posedge clk);
    node_reg = node;
    wr_index <= gcr_pkg::REG_INCL;
    wr_data <= incl;
    @(posedge clk);
    incl_reg = incl;
    wr_en <= 1'b0;
  endtask

  // Random latitude: mostly in range, some near the poles, some any angle.
  function automatic logic [31:0] random_lat();
    int pick;
    longint v;
    pick = $urandom_range(0, 9);
    if (pick < 7) v = longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000;
    else if (pick < 9) v = ($urandom_range(0, 1) ? 64'sh4000_0000 : -64'sh4000_0000)
                           + longint'($urandom_range(0, 64)) - 32;
    else v = longint'($urandom());
    return v[31:0];
  endfunction

  // Directed items: field extremes, poles, out-of-range latitudes, both directions.
  probe_t directed [] = '{
    '{DIR_TO_CIRCLE, 32'h0000_0000, 32'h0000_0000},
    '{DIR_TO_EQUATOR, 32'h0000_0000, 32'h0000_0000},
    '{DIR_TO_CIRCLE, 32'hFFFF_FFFF, 32'h0000_0000},
    '{DIR_TO_EQUATOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{DIR_TO_CIRCLE, 32'h8000_0000, 32'h4000_0000},
    '{DIR_TO_EQUATOR, 32'h8000_0000, 32'hC000_0000},
    '{DIR_TO_CIRCLE, 32'h438E_3855, 32'h4000_0000},
    '{DIR_TO_EQUATOR, 32'h438E_3855, 32'hC000_0000},
    '{DIR_TO_CIRCLE, 32'h1234_5678, 32'h7FFF_FFFF},
    '{DIR_TO_EQUATOR, 32'h1234_5678, 32'h8000_0000},
    '{DIR_TO_CIRCLE, 32'hC000_0000, 32'h4000_0001},
    '{DIR_TO_EQUATOR, 32'h4000_0000, 32'hBFFF_FFFF},
    '{DIR_TO_CIRCLE, 32'h0000_0001, 32'h3FFF_FFFF},
    '{DIR_TO_EQUATOR, 32'h7FFF_FFFF, 32'hC000_0001},
    '{DIR_TO_CIRCLE, 32'hAAAA_AAAA, 32'h5555_5555},
    '{DIR_TO_EQUATOR, 32'h5555_5555, 32'hAAAA_AAAA}
  };

  // Stimulus: reset, directed items, then random items over several circles.
  initial begin
    logic [31:0] phase_node [6];
    logic [31:0] phase_incl [6];
    phase_node = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0};
    phase_incl = '{32'h0, 32'hFFFF_FFFF, 32'h4000_0000, 32'h0, 32'h0, 32'h0};
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= gcr_pkg::REG_NODE;
    wr_data <= '0;
    in_valid <= 1'b0;
    direction <= DIR_TO_CIRCLE;
    lon_in <= '0;
    lat_in <= '0;
    node_reg = gcr_pkg::NODE_RESET;
    incl_reg = gcr_pkg::INCL_RESET;
    build_atan_turns();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) offer_item(directed[i].dir, directed[i].lon, directed[i].lat);
    for (int p = 0; p < 6; p++) begin
      if (p >= 3) begin
        phase_node[p] = $urandom();
        phase_incl[p] = $urandom();
      end
      if (p == 5) calm = 1'b1;
      load_circle(phase_node[p], phase_incl[p]);
      if (p < 3) begin
        foreach (directed[i]) offer_item(directed[i].dir, directed[i].lon, directed[i].lat);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        offer_item(1'($urandom_range(0, 1)), $urandom(), random_lat());
      end
    end
    in_valid <= 1'b0;

    while (pending_coords.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Output side back-pressure in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready <= 1'b1;
    end else if (!calm && $urandom_range(0, 19) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(1, 15);
    end
  end

  // Compare each delivered item with the oldest expectation.
  always @(posedge clk) begin
    coord_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_coords.size() == 0) begin
        $error("unexpected item: lon_out %h lat_out %h", lon_out, lat_out);
        failed = 1'b1;
      end else begin
        want = pending_coords.pop_front();
        if (lon_out !== want.lon) begin
          $error("lon_out: expected %h, actual %h", want.lon, lon_out);
          failed = 1'b1;
        end
        if (lat_out !== want.lat) begin
          $error("lat_out: expected %h, actual %h", want.lat, lat_out);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
rtl/core/gcr_pkg.sv
rtl/core/gcr_phase.sv
rtl/core/great_circle_coordinate_rotation.sv
bench/tb.sv
